// ===== design/aea_pkg.sv =====
// ----------------------------------------------------------------------------
// aea_pkg
// Operation codes, pipeline stage record and divider step for the expression
// ALU.
// ----------------------------------------------------------------------------
package aea_pkg;

    localparam logic [4:0] OP_MUL  = 5'd0;
    localparam logic [4:0] OP_DIV  = 5'd1;
    localparam logic [4:0] OP_MOD  = 5'd2;
    localparam logic [4:0] OP_SHL  = 5'd3;
    localparam logic [4:0] OP_SHR  = 5'd4;
    localparam logic [4:0] OP_ADD  = 5'd5;
    localparam logic [4:0] OP_SUB  = 5'd6;
    localparam logic [4:0] OP_AND  = 5'd7;
    localparam logic [4:0] OP_OR   = 5'd8;
    localparam logic [4:0] OP_XOR  = 5'd9;
    localparam logic [4:0] OP_EQ   = 5'd10;
    localparam logic [4:0] OP_NE   = 5'd11;
    localparam logic [4:0] OP_LT   = 5'd12;
    localparam logic [4:0] OP_GT   = 5'd13;
    localparam logic [4:0] OP_LE   = 5'd14;
    localparam logic [4:0] OP_GE   = 5'd15;
    localparam logic [4:0] OP_NEG  = 5'd16;
    localparam logic [4:0] OP_HIGH = 5'd17;
    localparam logic [4:0] OP_LOW  = 5'd18;
    localparam logic [4:0] OP_NOT  = 5'd19;

    localparam int          W          = 32;
    localparam int          BITS_STEP  = 4;
    localparam int          DIV_STAGES = W / BITS_STEP;
    localparam logic [W-1:0] TRUE_WORD = '1;
    localparam logic [W-1:0] LOW_MASK  = 32'h0000_00ff;
    localparam int          HIGH_SHIFT = 8;

    typedef struct packed {
        logic         is_div;
        logic         is_mod;
        logic         is_mul;
        logic         b_zero;
        logic         a_neg;
        logic         q_neg;
        logic [W-1:0] quick;
        logic [W-1:0] rem;
        logic [W-1:0] dvd;
        logic [W-1:0] dsr;
    } t_stage;

    // Four restoring-division steps; quotient bits shift into the dividend.
    function automatic t_stage div_step(input t_stage s);
        t_stage       o;
        logic [W-1:0] r;
        o = s;
        for (int i = 0; i < BITS_STEP; i++) begin
            r = {o.rem[W-2:0], o.dvd[W-1]};
            o.dvd = {o.dvd[W-2:0], 1'b0};
            if (r >= o.dsr) begin
                r = r - o.dsr;
                o.dvd[0] = 1'b1;
            end
            o.rem = r;
        end
        return o;
    endfunction

endpackage

// ===== design/assembler_expression_alu.sv =====
// ----------------------------------------------------------------------------
// A request passes the input stage, the divider stages and the output
// register; one request can enter every cycle while o_stall is low. The
// divider sets the length, resolving four quotient bits in each of eight
// stages; every operation rides the same pipeline so results leave in order.
// A stall at the output holds only full stages, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
// assembler_expression_alu
// 32-bit signed expression ALU with pipelined multiply and divide.
// ----------------------------------------------------------------------------
module assembler_expression_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [4:0]  i_op,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [31:0] o_value,
    output logic        o_divide_error
);
    import aea_pkg::*;

    localparam int NS = DIV_STAGES + 1;

    logic [NS:0]  r_v;
    t_stage       r_st [0:NS-1];
    t_stage       n_st [0:NS-1];
    t_stage       n_in;
    logic [NS:0]  adv;
    logic [W-1:0] r_value, n_value;
    logic         r_err, n_err;

    logic [W-1:0] a, b, amag, bmag, quick;
    logic         lt, gt, eq, b_big;

    assign a = i_operand_a;
    assign b = i_operand_b;

    always_comb begin
        amag  = a[W-1] ? (~a + 1'b1) : a;
        bmag  = b[W-1] ? (~b + 1'b1) : b;
        eq    = (a == b);
        lt    = $signed(a) < $signed(b);
        gt    = !lt && !eq;
        b_big = |b[W-1:5];
        case (i_op)
            OP_SHL:  quick = b_big ? '0 : (a << b[4:0]);
            OP_SHR:  quick = b_big ? {W{a[W-1]}} : W'($signed(a) >>> b[4:0]);
            OP_ADD:  quick = a + b;
            OP_SUB:  quick = a - b;
            OP_AND:  quick = a & b;
            OP_OR:   quick = a | b;
            OP_XOR:  quick = a ^ b;
            OP_EQ:   quick = eq ? TRUE_WORD : '0;
            OP_NE:   quick = !eq ? TRUE_WORD : '0;
            OP_LT:   quick = lt ? TRUE_WORD : '0;
            OP_GT:   quick = gt ? TRUE_WORD : '0;
            OP_LE:   quick = !gt ? TRUE_WORD : '0;
            OP_GE:   quick = !lt ? TRUE_WORD : '0;
            OP_NEG:  quick = ~a + 1'b1;
            OP_HIGH: quick = W'($signed(a) >>> HIGH_SHIFT);
            OP_LOW:  quick = a & LOW_MASK;
            OP_NOT:  quick = ~a;
            default: quick = '0;
        endcase
        n_in.is_div = (i_op == OP_DIV);
        n_in.is_mod = (i_op == OP_MOD);
        n_in.is_mul = (i_op == OP_MUL);
        n_in.b_zero = (b == '0);
        n_in.a_neg  = a[W-1];
        n_in.q_neg  = a[W-1] ^ b[W-1];
        n_in.quick  = quick;
        n_in.rem    = '0;
        n_in.dvd    = amag;
        n_in.dsr    = bmag;
    end

    // The low word of the product is taken from magnitudes and sign-fixed.
    always_comb begin
        logic [W-1:0] p;
        n_st[0] = n_in;
        p = W'(r_st[0].dvd * r_st[0].dsr);
        n_st[1] = div_step(r_st[0]);
        if (r_st[0].is_mul) begin
            n_st[1].quick = r_st[0].q_neg ? (~p + 1'b1) : p;
        end
        for (int k = 2; k < NS; k++) begin
            n_st[k] = div_step(r_st[k-1]);
        end
    end

    always_comb begin
        t_stage       s;
        logic [W-1:0] m;
        s = r_st[NS-1];
        m = s.is_div ? s.dvd : s.rem;
        n_err   = (s.is_div || s.is_mod) && s.b_zero;
        n_value = s.quick;
        if (s.is_div || s.is_mod) begin
            if (s.b_zero) begin
                n_value = '0;
            end else if (s.is_div ? s.q_neg : s.a_neg) begin
                n_value = ~m + 1'b1;
            end else begin
                n_value = m;
            end
        end
    end

    always_comb begin
        adv[NS] = !r_v[NS] || !i_stall;
        for (int k = NS - 1; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k <= NS; k++) begin
                if (adv[k]) r_v[k] <= r_v[k-1];
            end
        end
        if (adv[0]) r_st[0] <= n_st[0];
        for (int k = 1; k < NS; k++) begin
            if (adv[k]) r_st[k] <= n_st[k];
        end
        if (adv[NS]) begin
            r_value <= n_value;
            r_err   <= n_err;
        end
    end

    assign o_stall        = !adv[0];
    assign o_valid        = r_v[NS];
    assign o_value        = r_value;
    assign o_divide_error = r_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |-> o_value == '0)
        else $error("divide error with nonzero value");
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output free");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule
